>>> hdl/jbt_pkg.sv
// Shared types, character codes and helpers of the JSON byte tokenizer.
`timescale 1ns / 1ps
`default_nettype none

package jbt_pkg;

  localparam int PosW     = 16;
  localparam int WinDepth = 5;

  localparam logic [2:0] FillFull  = 3'd5;
  localparam logic [2:0] DropNone  = 3'd0;
  localparam logic [2:0] DropOne   = 3'd1;
  localparam logic [2:0] DropTrue  = 3'd4;
  localparam logic [2:0] DropFalse = 3'd5;
  localparam logic [2:0] NeedOne   = 3'd1;
  localparam logic [2:0] NeedDot   = 3'd2;
  localparam logic [2:0] NeedTrue  = 3'd4;
  localparam logic [2:0] NeedFalse = 3'd5;

  localparam logic [PosW-1:0] LenOne   = PosW'(1);
  localparam logic [PosW-1:0] LenTrue  = PosW'(4);
  localparam logic [PosW-1:0] LenFalse = PosW'(5);

  localparam logic [7:0] ChQuote   = 8'h22;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChNewline = 8'h0a;
  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChComma   = 8'h2c;
  localparam logic [7:0] ChColon   = 8'h3a;
  localparam logic [7:0] ChObjOpen = 8'h7b;
  localparam logic [7:0] ChObjClose = 8'h7d;
  localparam logic [7:0] ChLstOpen = 8'h5b;
  localparam logic [7:0] ChLstClose = 8'h5d;
  localparam logic [7:0] ChDot     = 8'h2e;
  localparam logic [7:0] ChLowT    = 8'h74;
  localparam logic [7:0] ChLowF    = 8'h66;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;

  localparam logic [31:0] WordTrue  = "true";
  localparam logic [39:0] WordFalse = "false";

  typedef enum logic [3:0] {
    KindString    = 4'd0,
    KindComma     = 4'd1,
    KindColon     = 4'd2,
    KindObjOpen   = 4'd3,
    KindObjClose  = 4'd4,
    KindListOpen  = 4'd5,
    KindListClose = 4'd6,
    KindTrue      = 4'd7,
    KindFalse     = 4'd8,
    KindNumber    = 4'd9,
    KindFloat     = 4'd10,
    KindUnknown   = 4'd11,
    KindEmpty     = 4'd12
  } token_kind_e;

  // Window contents as seen by the decision logic
  typedef struct packed {
    logic [WinDepth-1:0][7:0] ent;
    logic [2:0]               fill;
    logic                     eos;
  } win_view_t;

  // Window update from the decision logic
  typedef struct packed {
    logic [2:0] drop;
    logic       clear;
  } win_ctrl_t;

  typedef struct packed {
    logic            valid;
    logic            last;
    token_kind_e     kind;
    logic [PosW-1:0] start;
    logic [PosW-1:0] len;
  } token_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

  function automatic logic [PosW-1:0] sat_add(input logic [PosW-1:0] a,
                                               input logic [2:0] k);
    logic [PosW:0] s;
    s = {1'b0, a} + (PosW + 1)'(k);
    return s[PosW] ? {PosW{1'b1}} : s[PosW-1:0];
  endfunction

endpackage

`default_nettype wire

>>> hdl/jbt_window.sv
// Lookahead window: five-byte shift queue with fill count and end-of-stream flag.
`timescale 1ns / 1ps
`default_nettype none

module jbt_window (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               acc_i,
  input  wire logic [7:0]         byte_i,
  input  wire logic               eos_i,
  input  wire jbt_pkg::win_ctrl_t ctrl_i,
  output jbt_pkg::win_view_t      view_o
);

  logic [jbt_pkg::WinDepth-1:0][7:0] ent_q, ent_d, shifted;
  logic [2:0] fill_q, fill_d, fill_after;
  logic       eos_q, eos_d;
  logic       push;

  always_comb begin
    shifted    = ent_q >> {ctrl_i.drop, 3'b000};
    fill_after = fill_q - ctrl_i.drop;
    // zero bytes never enter the window
    push       = acc_i && (byte_i != 8'h00);
    ent_d      = shifted;
    for (int i = 0; i < jbt_pkg::WinDepth; i++) begin
      if (push && (fill_after == 3'(i))) begin
        ent_d[i] = byte_i;
      end
    end
    fill_d = fill_after + 3'(push);
    eos_d  = eos_q | (acc_i & eos_i);
    if (ctrl_i.clear) begin
      fill_d = 3'd0;
      eos_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= 3'd0;
      eos_q  <= 1'b0;
    end else begin
      fill_q <= fill_d;
      eos_q  <= eos_d;
    end
  end

  assign view_o.ent  = ent_q;
  assign view_o.fill = fill_q;
  assign view_o.eos  = eos_q;

endmodule

`default_nettype wire

>>> hdl/jbt_decide.sv
// Token decision: decides the window head, holds the pending token and positions.
`timescale 1ns / 1ps
`default_nettype none

module jbt_decide (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               step_en_i,
  input  wire jbt_pkg::win_view_t view_i,
  output jbt_pkg::win_ctrl_t      ctrl_o,
  output jbt_pkg::token_t         res_o
);

  logic in_string_q, in_string_d;
  logic group_q, group_d;
  logic pend_valid_q, pend_valid_d;
  jbt_pkg::token_kind_e pend_kind_q, pend_kind_d;
  logic [jbt_pkg::PosW-1:0] pend_start_q, pend_start_d;
  logic [jbt_pkg::PosW-1:0] pend_len_q, pend_len_d;
  logic [jbt_pkg::PosW-1:0] pos_q, pos_d;

  logic [jbt_pkg::WinDepth-1:0][7:0] peek;
  logic [7:0] head;
  logic [2:0] needed;
  logic       match_true, match_false;
  logic       can_decide, do_decide, do_final;
  logic       add_en, extend_en, float_en;
  jbt_pkg::token_kind_e add_kind;
  logic [jbt_pkg::PosW-1:0] add_len;

  // bytes past the fill read as zero, which matches no character
  always_comb begin
    for (int i = 0; i < jbt_pkg::WinDepth; i++) begin
      peek[i] = (3'(i) < view_i.fill) ? view_i.ent[i] : 8'h00;
    end
    head        = peek[0];
    match_true  = ({peek[0], peek[1], peek[2], peek[3]} == jbt_pkg::WordTrue);
    match_false = ({peek[0], peek[1], peek[2], peek[3], peek[4]} == jbt_pkg::WordFalse);

    needed = jbt_pkg::NeedOne;
    if (!in_string_q) begin
      if (!group_q && (head == jbt_pkg::ChLowT)) begin
        needed = jbt_pkg::NeedTrue;
      end else if (!group_q && (head == jbt_pkg::ChLowF)) begin
        needed = jbt_pkg::NeedFalse;
      end else if (group_q && (head == jbt_pkg::ChDot)) begin
        needed = jbt_pkg::NeedDot;
      end
    end
    // at end of stream the head is decided with whatever lookahead is left
    can_decide = (view_i.fill != 3'd0) && ((view_i.fill >= needed) || view_i.eos);
    do_decide  = step_en_i && can_decide;
    do_final   = step_en_i && view_i.eos && (view_i.fill == 3'd0);
  end

  always_comb begin
    in_string_d  = in_string_q;
    group_d      = group_q;
    pend_valid_d = pend_valid_q;
    pend_kind_d  = pend_kind_q;
    pend_start_d = pend_start_q;
    pend_len_d   = pend_len_q;
    pos_d        = pos_q;
    ctrl_o       = '0;
    res_o        = '0;
    add_en       = 1'b0;
    extend_en    = 1'b0;
    float_en     = 1'b0;
    add_kind     = jbt_pkg::KindUnknown;
    add_len      = jbt_pkg::LenOne;

    if (do_decide) begin
      ctrl_o.drop = jbt_pkg::DropOne;
      if (in_string_q) begin
        extend_en = 1'b1;
        if (head == jbt_pkg::ChQuote) begin
          in_string_d = 1'b0;
        end
      end else begin
        case (head) inside
          jbt_pkg::ChQuote: begin
            in_string_d = 1'b1;
            add_en      = 1'b1;
            add_kind    = jbt_pkg::KindString;
          end
          jbt_pkg::ChSpace, jbt_pkg::ChNewline, jbt_pkg::ChTab: begin
            group_d = 1'b0;
          end
          jbt_pkg::ChComma: begin
            add_en   = 1'b1;
            add_kind = jbt_pkg::KindComma;
            group_d  = 1'b0;
          end
          jbt_pkg::ChColon: begin
            add_en   = 1'b1;
            add_kind = jbt_pkg::KindColon;
            group_d  = 1'b0;
          end
          jbt_pkg::ChObjOpen: begin
            add_en   = 1'b1;
            add_kind = jbt_pkg::KindObjOpen;
          end
          jbt_pkg::ChObjClose: begin
            add_en   = 1'b1;
            add_kind = jbt_pkg::KindObjClose;
            group_d  = 1'b0;
          end
          jbt_pkg::ChLstOpen: begin
            add_en   = 1'b1;
            add_kind = jbt_pkg::KindListOpen;
          end
          jbt_pkg::ChLstClose: begin
            add_en   = 1'b1;
            add_kind = jbt_pkg::KindListClose;
            group_d  = 1'b0;
          end
          default: begin
            if (!group_q) begin
              if (match_true) begin
                // consume the whole word at once
                add_en      = 1'b1;
                add_kind    = jbt_pkg::KindTrue;
                add_len     = jbt_pkg::LenTrue;
                ctrl_o.drop = jbt_pkg::DropTrue;
              end else if (match_false) begin
                add_en      = 1'b1;
                add_kind    = jbt_pkg::KindFalse;
                add_len     = jbt_pkg::LenFalse;
                ctrl_o.drop = jbt_pkg::DropFalse;
              end else if (jbt_pkg::is_digit(head)) begin
                group_d  = 1'b1;
                add_en   = 1'b1;
                add_kind = jbt_pkg::KindNumber;
              end else if (pend_valid_q && (pend_kind_q == jbt_pkg::KindUnknown)) begin
                extend_en = 1'b1;
              end else begin
                add_en = 1'b1;
              end
            end else begin
              if (jbt_pkg::is_digit(head)) begin
                extend_en = 1'b1;
              end else if ((head == jbt_pkg::ChDot) && jbt_pkg::is_digit(peek[1])) begin
                float_en  = 1'b1;
                extend_en = 1'b1;
              end else begin
                add_en = 1'b1;
              end
            end
          end
        endcase
      end

      if (extend_en && pend_valid_q) begin
        pend_len_d = jbt_pkg::sat_add(pend_len_q, jbt_pkg::DropOne);
      end
      if (float_en && pend_valid_q) begin
        pend_kind_d = jbt_pkg::KindFloat;
      end
      // a new token closes the pending one
      if (add_en) begin
        res_o.valid  = pend_valid_q;
        res_o.kind   = pend_kind_q;
        res_o.start  = pend_start_q;
        res_o.len    = pend_len_q;
        pend_valid_d = 1'b1;
        pend_kind_d  = add_kind;
        pend_start_d = pos_q;
        pend_len_d   = add_len;
      end
      pos_d = jbt_pkg::sat_add(pos_q, ctrl_o.drop);
    end else if (do_final) begin
      res_o.valid = 1'b1;
      res_o.last  = 1'b1;
      if (pend_valid_q) begin
        res_o.kind  = pend_kind_q;
        res_o.start = pend_start_q;
        res_o.len   = pend_len_q;
      end else begin
        res_o.kind = jbt_pkg::KindEmpty;
      end
      in_string_d  = 1'b0;
      group_d      = 1'b0;
      pend_valid_d = 1'b0;
      pos_d        = '0;
      ctrl_o.clear = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_kind_q  <= pend_kind_d;
    pend_start_q <= pend_start_d;
    pend_len_q   <= pend_len_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_string_q  <= 1'b0;
      group_q      <= 1'b0;
      pend_valid_q <= 1'b0;
      pos_q        <= '0;
    end else begin
      in_string_q  <= in_string_d;
      group_q      <= group_d;
      pend_valid_q <= pend_valid_d;
      pos_q        <= pos_d;
    end
  end

endmodule

`default_nettype wire

>>> hdl/json_byte_tokenizer.sv
// JSON byte tokenizer: splits a byte stream into kind/offset/length tokens.
//
// Input stream: one text byte per transfer in s_axis_tdata_i; s_axis_tlast_i marks
// the final byte of a stream. Zero bytes are dropped; a zero byte with tlast only
// ends the stream. Output stream: one token per transfer, kind in tuser, start
// offset and length in tdata, tlast on the final token of each stream (an empty
// stream gives a single token of kind empty).
// Throughput: one byte per cycle while the receiver takes tokens and the window
// is not full. Unless stalled, the decision logic decides one head byte per
// cycle from the window register; a held 't', 'f' or '.' waits for its following
// bytes, then a matched true or false is taken at once and other bytes one per
// cycle. tready is low whenever the five-byte window is full. A token is shown
// on the output the cycle after the decision that closes it.
// End of stream: after the tlast transfer tready stays low while the window
// drains and the final token is registered; the next byte starts a new stream
// at offset zero.
// A stalled receiver holds the output register and stops the decision logic; the
// window keeps taking bytes until it is full. Reset clears flags, fill and offset.
`timescale 1ns / 1ps
`default_nettype none

module json_byte_tokenizer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output      logic        s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] byte_in
  input  wire logic        s_axis_tlast_i,   // end_of_stream
  output      logic        m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output      logic [31:0] m_axis_tdata_o,   // [15:0] start_offset, [31:16] token_length
  output      logic [3:0]  m_axis_tuser_o,   // [3:0] token_kind
  output      logic        m_axis_tlast_o    // last_token
);

  jbt_pkg::win_view_t view;
  jbt_pkg::win_ctrl_t ctrl;
  jbt_pkg::token_t    dec_res;

  logic s_acc;
  logic out_free;
  logic m_valid_q, m_valid_d;
  logic [31:0] m_data_q;
  logic [3:0]  m_kind_q;
  logic        m_last_q;

  assign s_axis_tready_o = !view.eos && (view.fill != jbt_pkg::FillFull);
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;

  jbt_window u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .acc_i  (s_acc),
    .byte_i (s_axis_tdata_i),
    .eos_i  (s_axis_tlast_i),
    .ctrl_i (ctrl),
    .view_o (view)
  );

  jbt_decide u_decide (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (out_free),
    .view_i    (view),
    .ctrl_o    (ctrl),
    .res_o     (dec_res)
  );

  always_comb begin
    m_valid_d = m_valid_q;
    if (dec_res.valid) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dec_res.valid) begin
      m_data_q <= {dec_res.len, dec_res.start};
      m_kind_q <= dec_res.kind;
      m_last_q <= dec_res.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_kind_q;
  assign m_axis_tlast_o  = m_last_q;

  a_eos_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && s_axis_tlast_i |=> !s_axis_tready_o)
    else $error("input taken after end of stream");

  a_final_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dec_res.valid && dec_res.last |-> view.eos && (view.fill == 3'd0))
    else $error("final token before window drained");

  a_final_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dec_res.valid && dec_res.last |=> (view.fill == 3'd0) && !view.eos)
    else $error("window not cleared after final token");

  a_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dec_res.valid |-> out_free)
    else $error("token produced while output register busy");

endmodule

`default_nettype wire
